[rtl/core/mls_pkg.sv]
// Shared types, codes and sizing constants for the modem link sequencer.
package mls_pkg;

  localparam int MaxInitCmds = 16;
  localparam int TimerBits   = 24;

  localparam int InitPosW = $clog2(MaxInitCmds);
  localparam int CntCmpW  = 8;
  localparam int TimeCmpW = 32;

  localparam int NumRegs = 6;
  localparam int AddrW   = 5;

  // register indexes
  typedef enum logic [2:0] {
    REG_INIT_CMD_COUNT = 3'd0,
    REG_REPLY_TIMEOUT  = 3'd1,
    REG_ACK_TIMEOUT    = 3'd2,
    REG_SHORT_BACKOFF  = 3'd3,
    REG_LONG_BACKOFF   = 3'd4,
    REG_BACKOFF_LIMIT  = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    CMD_REPLY   = 3'd0,
    CMD_TICK    = 3'd1,
    CMD_SEND    = 3'd2,
    CMD_PWRDOWN = 3'd3,
    CMD_RESTART = 3'd4,
    CMD_START   = 3'd5,
    CMD_FRESET  = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    MSG_BANNER  = 3'd0,
    MSG_OK      = 3'd1,
    MSG_JOINED  = 3'd2,
    MSG_JFAILED = 3'd3,
    MSG_ACK     = 3'd4,
    MSG_NACK    = 3'd5,
    MSG_ECHO    = 3'd6,
    MSG_OTHER   = 3'd7
  } msg_kind_e;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_INIT    = 3'd1,
    ACT_JOIN    = 3'd2,
    ACT_DATA    = 3'd3,
    ACT_OFF     = 3'd4,
    ACT_ON      = 3'd5,
    ACT_OFF_ON  = 3'd6
  } action_e;

  typedef enum logic [1:0] {
    ACKR_NONE    = 2'd0,
    ACKR_ACKED   = 2'd1,
    ACKR_TIMEOUT = 2'd2
  } ack_report_e;

  // numeric mode codes seen on the result
  localparam logic [3:0] MODE_OFF       = 4'd0;
  localparam logic [3:0] MODE_INIT_OK   = 4'd1;
  localparam logic [3:0] MODE_INIT_ECHO = 4'd2;
  localparam logic [3:0] MODE_JOIN_OK   = 4'd3;
  localparam logic [3:0] MODE_JOIN_ECHO = 4'd4;
  localparam logic [3:0] MODE_JOIN_WAIT = 4'd5;
  localparam logic [3:0] MODE_RESETTING = 4'd6;
  localparam logic [3:0] MODE_IDLE      = 4'd7;
  localparam logic [3:0] MODE_SEND_ECHO = 4'd8;
  localparam logic [3:0] MODE_SEND_OK   = 4'd9;
  localparam logic [3:0] MODE_SEND_ACK  = 4'd10;

  typedef enum logic [10:0] {
    ST_OFF       = 11'b000_0000_0001,
    ST_INIT_OK   = 11'b000_0000_0010,
    ST_INIT_ECHO = 11'b000_0000_0100,
    ST_JOIN_OK   = 11'b000_0000_1000,
    ST_JOIN_ECHO = 11'b000_0001_0000,
    ST_JOIN_WAIT = 11'b000_0010_0000,
    ST_RESETTING = 11'b000_0100_0000,
    ST_IDLE      = 11'b000_1000_0000,
    ST_SEND_ECHO = 11'b001_0000_0000,
    ST_SEND_OK   = 11'b010_0000_0000,
    ST_SEND_ACK  = 11'b100_0000_0000
  } link_state_e;

  function automatic logic [3:0] mode_of(link_state_e s);
    logic [3:0] m;
    case (s)
      ST_OFF:       m = MODE_OFF;
      ST_INIT_OK:   m = MODE_INIT_OK;
      ST_INIT_ECHO: m = MODE_INIT_ECHO;
      ST_JOIN_OK:   m = MODE_JOIN_OK;
      ST_JOIN_ECHO: m = MODE_JOIN_ECHO;
      ST_JOIN_WAIT: m = MODE_JOIN_WAIT;
      ST_RESETTING: m = MODE_RESETTING;
      ST_IDLE:      m = MODE_IDLE;
      ST_SEND_ECHO: m = MODE_SEND_ECHO;
      ST_SEND_OK:   m = MODE_SEND_OK;
      ST_SEND_ACK:  m = MODE_SEND_ACK;
      default:      m = MODE_OFF;
    endcase
    return m;
  endfunction

endpackage

[rtl/core/modem_link_sequencer.sv]
// Modem link sequencer: input register, one-pass state update, result register.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+----------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready    | tuser {msg_kind, cmd}, tdata text_send
//  m_axis   | out | m_axis_tvalid/tready    | tdata {connected,mode,accepted,ack,idx,act}
//  apb      | in  | psel/penable/pwrite     | paddr = 4 * register index, pwdata
//
// A beat is held in the input register and is then evaluated combinationally against the
// link state, landing in the result register; one beat per cycle sustained while m_axis
// accepts. Back-pressure on m_axis stalls the evaluation and the input register, after
// which s_axis_tready falls. Reset clears the link state, counters, both valid flags and
// loads the register defaults.
module modem_link_sequencer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [0] text_send
  input  logic [5:0]                s_axis_tuser,   // [2:0] cmd, [5:3] msg_kind
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [2:0] action, [6:3] init_index, [8:7] ack_report, [9] accepted,
  // [13:10] mode, [14] connected
  output logic [15:0]               m_axis_tdata,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mls_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  // configuration
  logic [4:0]  init_cmd_count_q;
  logic [23:0] reply_timeout_q, ack_timeout_q, short_backoff_q, long_backoff_q;
  logic [3:0]  backoff_limit_q;
  logic        cfg_wr;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_cmd_count_q <= 5'd10;
      reply_timeout_q  <= 24'd15000;
      ack_timeout_q    <= 24'd20000;
      short_backoff_q  <= 24'd10;
      long_backoff_q   <= 24'd900000;
      backoff_limit_q  <= 4'd5;
    end else if (cfg_wr) begin
      case (reg_idx)
        mls_pkg::REG_INIT_CMD_COUNT: init_cmd_count_q <= pwdata[4:0];
        mls_pkg::REG_REPLY_TIMEOUT:  reply_timeout_q  <= pwdata[23:0];
        mls_pkg::REG_ACK_TIMEOUT:    ack_timeout_q    <= pwdata[23:0];
        mls_pkg::REG_SHORT_BACKOFF:  short_backoff_q  <= pwdata[23:0];
        mls_pkg::REG_LONG_BACKOFF:   long_backoff_q   <= pwdata[23:0];
        mls_pkg::REG_BACKOFF_LIMIT:  backoff_limit_q  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mls_pkg::REG_INIT_CMD_COUNT: prdata = {27'd0, init_cmd_count_q};
      mls_pkg::REG_REPLY_TIMEOUT:  prdata = {8'd0, reply_timeout_q};
      mls_pkg::REG_ACK_TIMEOUT:    prdata = {8'd0, ack_timeout_q};
      mls_pkg::REG_SHORT_BACKOFF:  prdata = {8'd0, short_backoff_q};
      mls_pkg::REG_LONG_BACKOFF:   prdata = {8'd0, long_backoff_q};
      mls_pkg::REG_BACKOFF_LIMIT:  prdata = {28'd0, backoff_limit_q};
      default:                     prdata = 32'd0;
    endcase
  end

  // input register
  logic       in_valid_q;
  logic [2:0] cmd_q, kind_q;
  logic       text_q;
  logic       out_valid_q;
  logic       adv;

  assign adv           = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      cmd_q  <= s_axis_tuser[2:0];
      kind_q <= s_axis_tuser[5:3];
      text_q <= s_axis_tdata[0];
    end
  end

  // link state
  mls_pkg::link_state_e            state_q, state_d;
  logic [mls_pkg::InitPosW-1:0]    pos_q, pos_d;
  logic [mls_pkg::TimerBits-1:0]   elapsed_q, elapsed_d, elapsed_inc;
  logic [3:0]                      rir_q, rir_d;

  logic [2:0]                      act;
  logic [3:0]                      idx;
  logic [1:0]                      ackr;
  logic                            acc;
  logic                            rst_req;
  logic [mls_pkg::CntCmpW-1:0]     eff_cnt, pos_next;
  logic [mls_pkg::TimeCmpW-1:0]    elapsed_ext, backoff_ext;

  assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
  assign elapsed_ext = mls_pkg::TimeCmpW'(elapsed_inc);
  assign backoff_ext = (rir_q >= backoff_limit_q) ? mls_pkg::TimeCmpW'(long_backoff_q)
                                                  : mls_pkg::TimeCmpW'(short_backoff_q);
  assign pos_next    = mls_pkg::CntCmpW'(pos_q) + 1'b1;

  always_comb begin
    eff_cnt = mls_pkg::CntCmpW'(init_cmd_count_q);
    if (init_cmd_count_q == 5'd0) begin
      eff_cnt = mls_pkg::CntCmpW'(1);
    end else if (eff_cnt > mls_pkg::CntCmpW'(mls_pkg::MaxInitCmds)) begin
      eff_cnt = mls_pkg::CntCmpW'(mls_pkg::MaxInitCmds);
    end
  end

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    elapsed_d = elapsed_q;
    rir_d     = rir_q;
    act       = mls_pkg::ACT_NONE;
    idx       = 4'd0;
    ackr      = mls_pkg::ACKR_NONE;
    acc       = 1'b0;
    rst_req   = 1'b0;

    case (cmd_q)
      mls_pkg::CMD_REPLY: begin
        case (state_q)
          mls_pkg::ST_OFF: begin
            if (kind_q == mls_pkg::MSG_BANNER) begin
              state_d   = mls_pkg::ST_INIT_OK;
              pos_d     = '0;
              act       = mls_pkg::ACT_INIT;
              elapsed_d = '0;
            end
          end
          mls_pkg::ST_INIT_ECHO: begin
            if (kind_q == mls_pkg::MSG_ECHO) state_d = mls_pkg::ST_INIT_OK;
          end
          mls_pkg::ST_INIT_OK: begin
            if (kind_q == mls_pkg::MSG_OK) begin
              elapsed_d = '0;
              if (pos_next >= eff_cnt) begin
                state_d = mls_pkg::ST_JOIN_ECHO;
                act     = mls_pkg::ACT_JOIN;
              end else begin
                pos_d   = pos_q + 1'b1;
                state_d = mls_pkg::ST_INIT_ECHO;
                act     = mls_pkg::ACT_INIT;
                idx     = 4'(pos_next);
              end
            end
          end
          mls_pkg::ST_JOIN_ECHO: begin
            if (kind_q == mls_pkg::MSG_ECHO) state_d = mls_pkg::ST_JOIN_OK;
          end
          mls_pkg::ST_JOIN_OK: begin
            if (kind_q == mls_pkg::MSG_OK) state_d = mls_pkg::ST_JOIN_WAIT;
          end
          mls_pkg::ST_JOIN_WAIT: begin
            if (kind_q == mls_pkg::MSG_JOINED) state_d = mls_pkg::ST_IDLE;
            else if (kind_q == mls_pkg::MSG_JFAILED) rst_req = 1'b1;
          end
          mls_pkg::ST_SEND_ECHO: begin
            if (kind_q == mls_pkg::MSG_ECHO) state_d = mls_pkg::ST_SEND_OK;
          end
          mls_pkg::ST_SEND_OK: begin
            if (kind_q == mls_pkg::MSG_OK) state_d = mls_pkg::ST_SEND_ACK;
          end
          mls_pkg::ST_SEND_ACK: begin
            if (kind_q == mls_pkg::MSG_ACK) begin
              rir_d   = 4'd0;
              ackr    = mls_pkg::ACKR_ACKED;
              state_d = mls_pkg::ST_IDLE;
            end else if (kind_q == mls_pkg::MSG_NACK) begin
              rst_req = 1'b1;
            end
          end
          default: ;
        endcase
      end
      mls_pkg::CMD_TICK: begin
        elapsed_d = elapsed_inc;
        case (state_q)
          mls_pkg::ST_OFF, mls_pkg::ST_IDLE: ;
          mls_pkg::ST_RESETTING: begin
            if (elapsed_ext > backoff_ext) begin
              state_d = mls_pkg::ST_OFF;
              act     = mls_pkg::ACT_ON;
            end
          end
          mls_pkg::ST_SEND_ACK: begin
            if (elapsed_ext > mls_pkg::TimeCmpW'(ack_timeout_q)) begin
              ackr    = mls_pkg::ACKR_TIMEOUT;
              rst_req = 1'b1;
            end
          end
          default: begin
            if (elapsed_ext > mls_pkg::TimeCmpW'(reply_timeout_q)) rst_req = 1'b1;
          end
        endcase
      end
      mls_pkg::CMD_SEND: begin
        if (state_q == mls_pkg::ST_IDLE) begin
          acc       = 1'b1;
          state_d   = text_q ? mls_pkg::ST_SEND_ECHO : mls_pkg::ST_SEND_OK;
          act       = mls_pkg::ACT_DATA;
          elapsed_d = '0;
        end
      end
      mls_pkg::CMD_PWRDOWN: begin
        state_d = mls_pkg::ST_OFF;
        act     = mls_pkg::ACT_OFF;
      end
      mls_pkg::CMD_RESTART: begin
        state_d = mls_pkg::ST_OFF;
        rir_d   = 4'd0;
        act     = mls_pkg::ACT_OFF_ON;
      end
      mls_pkg::CMD_START: begin
        state_d = mls_pkg::ST_OFF;
        act     = mls_pkg::ACT_ON;
      end
      mls_pkg::CMD_FRESET: rst_req = 1'b1;
      default: ;
    endcase

    // a reset request is dropped while one is already running
    if (rst_req && state_q != mls_pkg::ST_RESETTING) begin
      state_d   = mls_pkg::ST_RESETTING;
      elapsed_d = '0;
      act       = mls_pkg::ACT_OFF;
      if (rir_q < backoff_limit_q) rir_d = rir_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mls_pkg::ST_OFF;
      pos_q     <= '0;
      elapsed_q <= '0;
      rir_q     <= 4'd0;
    end else if (adv) begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      elapsed_q <= elapsed_d;
      rir_q     <= rir_d;
    end
  end

  // result register
  logic [3:0]  mode_d;
  logic        conn_d;
  logic [15:0] res_q;

  assign mode_d = mls_pkg::mode_of(state_d);
  assign conn_d = (mode_d >= mls_pkg::MODE_IDLE) && (mode_d <= mls_pkg::MODE_SEND_ACK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (~out_valid_q | m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= {1'b0, conn_d, mode_d, acc, ackr, idx, act};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;

`ifndef NO_ASSERTIONS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("link state not one-hot");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q) else $error("input beat lost under stall");

  a_init_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && act == mls_pkg::ACT_INIT |=>
      res_q[13:10] == mls_pkg::MODE_INIT_OK || res_q[13:10] == mls_pkg::MODE_INIT_ECHO)
    else $error("init command without init wait state");

  a_accept_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && acc |-> act == mls_pkg::ACT_DATA &&
      (state_d == mls_pkg::ST_SEND_ECHO || state_d == mls_pkg::ST_SEND_OK))
    else $error("accepted send without data action");

  a_ack_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && ackr == mls_pkg::ACKR_ACKED |=> state_q == mls_pkg::ST_IDLE && rir_q == 4'd0)
    else $error("acknowledge did not return to idle");
`endif

endmodule

[verif/mls_link_check.sv]
// Scoreboard for the modem link sequencer: mirrors the link state, predicts and checks result beats.
module mls_link_check
  import mls_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  input  logic             s_tready_i,
  input  logic [7:0]       s_tdata_i,   // [0] text_send
  input  logic [5:0]       s_tuser_i,   // [2:0] cmd, [5:3] msg_kind
  input  logic             m_tvalid_i,
  input  logic             m_tready_i,
  // [2:0] action, [6:3] init_index, [8:7] ack_report, [9] accepted,
  // [13:10] mode, [14] connected
  input  logic [15:0]      m_tdata_i,
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic             pready_i,
  input  logic [AddrW-1:0] paddr_i,
  input  logic [31:0]      pwdata_i,
  output int               errors_o,
  output int               pending_o
);

  typedef struct packed {
    logic        connected;
    logic [3:0]  mode;
    logic        accepted;
    ack_report_e ack_report;
    logic [3:0]  init_index;
    action_e     action;
  } link_result_t;

  logic [4:0]           cfg_init_count;
  logic [TimerBits-1:0] cfg_reply_to;
  logic [TimerBits-1:0] cfg_ack_to;
  logic [TimerBits-1:0] cfg_short_bo;
  logic [TimerBits-1:0] cfg_long_bo;
  logic [3:0]           cfg_bo_limit;

  logic [3:0]           link_mode;
  logic [InitPosW-1:0]  init_pos;
  logic [TimerBits-1:0] tick_count;
  logic [3:0]           reset_run;

  link_result_t due_results[$];
  link_result_t next_res;
  int           errors;

  // a reset while already resetting changes nothing
  function automatic void enter_reset();
    if (link_mode != MODE_RESETTING) begin
      link_mode = MODE_RESETTING;
      if (reset_run < cfg_bo_limit) reset_run++;
      tick_count = '0;
      next_res.action = ACT_OFF;
    end
  endfunction

  function automatic link_result_t advance_link(input logic [2:0] cmd, input logic [2:0] kind,
                                                input logic text);
    int                   eff;
    logic [TimerBits-1:0] hold;
    eff = (cfg_init_count == 5'd0) ? 1 :
          ((cfg_init_count > MaxInitCmds) ? MaxInitCmds : int'(cfg_init_count));
    next_res = '0;
    case (cmd)
      CMD_REPLY: begin
        case (link_mode)
          MODE_OFF: if (kind == MSG_BANNER) begin
            link_mode = MODE_INIT_OK;
            init_pos = '0;
            tick_count = '0;
            next_res.action = ACT_INIT;
          end
          MODE_INIT_ECHO: if (kind == MSG_ECHO) link_mode = MODE_INIT_OK;
          MODE_INIT_OK: if (kind == MSG_OK) begin
            if (int'(init_pos) + 1 >= eff) begin
              link_mode = MODE_JOIN_ECHO;
              next_res.action = ACT_JOIN;
            end else begin
              init_pos++;
              link_mode = MODE_INIT_ECHO;
              next_res.action = ACT_INIT;
              next_res.init_index = init_pos;
            end
            tick_count = '0;
          end
          MODE_JOIN_ECHO: if (kind == MSG_ECHO) link_mode = MODE_JOIN_OK;
          MODE_JOIN_OK: if (kind == MSG_OK) link_mode = MODE_JOIN_WAIT;
          MODE_JOIN_WAIT: begin
            if (kind == MSG_JOINED) link_mode = MODE_IDLE;
            else if (kind == MSG_JFAILED) enter_reset();
          end
          MODE_SEND_ECHO: if (kind == MSG_ECHO) link_mode = MODE_SEND_OK;
          MODE_SEND_OK: if (kind == MSG_OK) link_mode = MODE_SEND_ACK;
          MODE_SEND_ACK: begin
            if (kind == MSG_ACK) begin
              reset_run = '0;
              next_res.ack_report = ACKR_ACKED;
              link_mode = MODE_IDLE;
            end else if (kind == MSG_NACK) begin
              enter_reset();
            end
          end
          default: ;
        endcase
      end
      CMD_TICK: begin
        if (tick_count != '1) tick_count++;
        case (link_mode)
          MODE_OFF, MODE_IDLE: ;
          MODE_RESETTING: begin
            hold = (reset_run >= cfg_bo_limit) ? cfg_long_bo : cfg_short_bo;
            if (tick_count > hold) begin
              link_mode = MODE_OFF;
              next_res.action = ACT_ON;
            end
          end
          MODE_SEND_ACK: if (tick_count > cfg_ack_to) begin
            next_res.ack_report = ACKR_TIMEOUT;
            enter_reset();
          end
          default: if (tick_count > cfg_reply_to) enter_reset();
        endcase
      end
      CMD_SEND: if (link_mode == MODE_IDLE) begin
        next_res.accepted = 1'b1;
        link_mode = text ? MODE_SEND_ECHO : MODE_SEND_OK;
        tick_count = '0;
        next_res.action = ACT_DATA;
      end
      CMD_PWRDOWN: begin
        link_mode = MODE_OFF;
        next_res.action = ACT_OFF;
      end
      CMD_RESTART: begin
        link_mode = MODE_OFF;
        reset_run = '0;
        next_res.action = ACT_OFF_ON;
      end
      CMD_START: begin
        link_mode = MODE_OFF;
        next_res.action = ACT_ON;
      end
      CMD_FRESET: enter_reset();
      default: ;
    endcase
    next_res.mode = link_mode;
    next_res.connected = (link_mode >= MODE_IDLE) && (link_mode <= MODE_SEND_ACK);
    return next_res;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    link_result_t got;
    link_result_t want;
    if (!rst_ni) begin
      cfg_init_count = 5'd10;
      cfg_reply_to   = 24'd15000;
      cfg_ack_to     = 24'd20000;
      cfg_short_bo   = 24'd10;
      cfg_long_bo    = 24'd900000;
      cfg_bo_limit   = 4'd5;
      link_mode      = MODE_OFF;
      init_pos       = '0;
      tick_count     = '0;
      reset_run      = '0;
      due_results.delete();
      errors = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[AddrW-1:2]))
          REG_INIT_CMD_COUNT: cfg_init_count = pwdata_i[4:0];
          REG_REPLY_TIMEOUT:  cfg_reply_to   = pwdata_i[TimerBits-1:0];
          REG_ACK_TIMEOUT:    cfg_ack_to     = pwdata_i[TimerBits-1:0];
          REG_SHORT_BACKOFF:  cfg_short_bo   = pwdata_i[TimerBits-1:0];
          REG_LONG_BACKOFF:   cfg_long_bo    = pwdata_i[TimerBits-1:0];
          REG_BACKOFF_LIMIT:  cfg_bo_limit   = pwdata_i[3:0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        got = link_result_t'(m_tdata_i[14:0]);
        if (due_results.size() == 0) begin
          $error("result beat %h with nothing expected", m_tdata_i);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("action", want.action, got.action);
          check_field("init_index", want.init_index, got.init_index);
          check_field("ack_report", want.ack_report, got.ack_report);
          check_field("accepted", want.accepted, got.accepted);
          check_field("mode", want.mode, got.mode);
          check_field("connected", want.connected, got.connected);
        end
      end
      if (s_tvalid_i && s_tready_i)
        due_results.push_back(advance_link(s_tuser_i[2:0], s_tuser_i[5:3], s_tdata_i[0]));
      errors_o  <= errors;
      pending_o <= due_results.size();
    end
  end

endmodule

[verif/tb.sv]
// Testbench top for the modem link sequencer: clock, reset, stimulus, back-pressure, verdict.
module tb;
  import mls_pkg::*;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata  = '0;   // [0] text_send
  logic [5:0]       s_axis_tuser  = '0;   // [2:0] cmd, [5:3] msg_kind
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [15:0]      m_axis_tdata;         // action, init_index, ack_report, accepted, mode, connected
  logic             psel          = 1'b0;
  logic             penable       = 1'b0;
  logic             pwrite        = 1'b0;
  logic [AddrW-1:0] paddr         = '0;
  logic [31:0]      pwdata        = '0;
  logic [31:0]      prdata;
  logic             pready;

  int errors;
  int pending;
  bit quiet = 1'b0;        // no idling on either side in the final stretch
  int beats_sent = 0;
  int init_count_cur = 10;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  modem_link_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  mls_link_check u_link_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .pready_i   (pready),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  task automatic beat(input logic [2:0] cmd, input logic [2:0] kind, input logic text);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {kind, cmd};
    s_axis_tdata  <= {7'd0, text};
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
  endtask

  task automatic reply(input logic [2:0] kind);
    beat(CMD_REPLY, kind, 1'($urandom));
  endtask

  task automatic tick_n(input int n);
    repeat (n) beat(CMD_TICK, 3'($urandom), 1'($urandom));
  endtask

  // the pending count is registered, so let it settle past the current edge before trusting it
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [4:0] count, input logic [23:0] reply_to,
                            input logic [23:0] ack_to, input logic [23:0] short_bo,
                            input logic [23:0] long_bo, input logic [3:0] limit);
    apb_write(REG_INIT_CMD_COUNT, 32'(count));
    apb_write(REG_REPLY_TIMEOUT, 32'(reply_to));
    apb_write(REG_ACK_TIMEOUT, 32'(ack_to));
    apb_write(REG_SHORT_BACKOFF, 32'(short_bo));
    apb_write(REG_LONG_BACKOFF, 32'(long_bo));
    apb_write(REG_BACKOFF_LIMIT, 32'(limit));
    init_count_cur = (count == 5'd0) ? 1 : ((count > MaxInitCmds) ? MaxInitCmds : int'(count));
  endtask

  // optional power command, banner, init list, join; mostly well formed with the odd stray line or tick
  task automatic bring_up();
    case ($urandom_range(0, 3))
      0: beat(CMD_RESTART, 3'($urandom), 1'($urandom));
      1: beat(CMD_START, 3'($urandom), 1'($urandom));
      2: beat(CMD_PWRDOWN, 3'($urandom), 1'($urandom));
      default: ;
    endcase
    reply(MSG_BANNER);
    for (int i = 0; i < init_count_cur; i++) begin
      if (i > 0) reply(MSG_ECHO);
      if ($urandom_range(0, 11) == 0) reply(3'($urandom));
      tick_n(($urandom_range(0, 5) == 0) ? 1 : 0);
      reply(MSG_OK);
    end
    reply(MSG_ECHO);
    reply(MSG_OK);
    tick_n(($urandom_range(0, 4) == 0) ? 1 : 0);
    reply(($urandom_range(0, 5) == 0) ? MSG_JFAILED : MSG_JOINED);
  endtask

  task automatic send_cycle();
    logic text;
    text = 1'($urandom);
    beat(CMD_SEND, 3'($urandom), text);
    if (text) reply(MSG_ECHO);
    tick_n(($urandom_range(0, 4) == 0) ? 1 : 0);
    reply(MSG_OK);
    case ($urandom_range(0, 7))
      0: reply(MSG_NACK);
      1: tick_n($urandom_range(1, 10));
      2: reply(3'($urandom));
      default: reply(MSG_ACK);
    endcase
  endtask

  task automatic random_traffic(input int quota);
    int stop_at;
    stop_at = beats_sent + quota;
    while (beats_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0: beat(3'($urandom), 3'($urandom), 1'($urandom));
        1: begin
          beat(CMD_FRESET, 3'($urandom), 1'($urandom));
          tick_n($urandom_range(0, 6));
        end
        2: reply(3'($urandom));
        3: begin
          // bring-up abandoned half way
          beat(CMD_PWRDOWN, 3'($urandom), 1'($urandom));
          reply(MSG_BANNER);
          reply(MSG_OK);
          tick_n($urandom_range(0, 4));
        end
        default: begin
          bring_up();
          repeat ($urandom_range(1, 4)) send_cycle();
        end
      endcase
    end
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_config(5'd2, 24'd3, 24'd2, 24'd1, 24'd3, 4'd2);
    reply(MSG_OTHER);                    // stray line while off
    beat(CMD_SEND, MSG_OTHER, 1'b1);     // refused, not idle
    reply(MSG_BANNER);
    reply(MSG_OK);
    reply(MSG_OK);                       // OK while waiting for the echo
    reply(MSG_ECHO);
    reply(MSG_OK);
    reply(MSG_ECHO);
    reply(MSG_OK);
    reply(MSG_JOINED);
    beat(CMD_SEND, MSG_BANNER, 1'b1);
    beat(CMD_SEND, MSG_BANNER, 1'b0);    // busy
    reply(MSG_ECHO);
    reply(MSG_OK);
    reply(MSG_ACK);
    beat(CMD_SEND, MSG_OTHER, 1'b0);     // hex send, no echo
    reply(MSG_OK);
    tick_n(3);                           // acknowledge times out
    beat(CMD_FRESET, MSG_OTHER, 1'b1);   // already resetting
    tick_n(2);                           // short back-off over, chip on
    beat(3'b111, MSG_OTHER, 1'b1);       // unknown command
    beat(CMD_PWRDOWN, MSG_BANNER, 1'b0);
    beat(CMD_START, MSG_BANNER, 1'b0);
    beat(CMD_RESTART, MSG_BANNER, 1'b0);
    drain();

    for (int ph = 1; ph <= 8; ph++) begin
      case (ph)
        1: set_config(5'd0, 24'd1, 24'd1, 24'd0, 24'd0, 4'd1);
        2: set_config(5'd31, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 4'd15);
        3: set_config(5'd16, 24'd6, 24'd5, 24'd2, 24'd0, 4'd1);
        8: begin
          quiet = 1'b1;
          set_config(5'd3, 24'd4, 24'd3, 24'd1, 24'd2, 4'd3);
        end
        default: set_config(5'($urandom_range(0, 20)), 24'($urandom_range(1, 8)),
                            24'($urandom_range(1, 8)), 24'($urandom_range(0, 4)),
                            24'($urandom_range(0, 12)), 4'($urandom_range(1, 4)));
      endcase
      random_traffic(35);
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (errors == 0 && pending == 0) $display("[modem_link_sequencer] OK");
    else $display("[modem_link_sequencer] ERROR");
    $finish;
  end

  initial begin : result_sink
    int  taken;
    bit  long_hold_done;
    taken = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) taken++;
      if (!long_hold_done && taken >= 150) begin
        // long hold-off so the pipe fills and s_axis_tready drops
        long_hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (100) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #400000;
    $display("[modem_link_sequencer] ERROR");
    $finish;
  end

endmodule
